[hw/rtl/stbt_pkg.sv]
`default_nettype none

package stbt_pkg;

    // bank geometry
    localparam int PLAIN_SLOTS    = 8;
    localparam int CALLBACK_SLOTS = 8;
    localparam int COUNT_BITS     = 16;

    // transaction field widths
    localparam int OP_BITS    = 3;
    localparam int SLOT_BITS  = 3;
    localparam int LOAD_BITS  = 16;
    localparam int MASK_BITS  = 8;
    localparam int VALUE_BITS = 16;

    typedef logic [COUNT_BITS-1:0] count_t;

    // operation codes, code 7 is unused
    typedef enum logic [OP_BITS-1:0] {
        OP_TICK           = 3'd0,
        OP_ENROLL_PLAIN   = 3'd1,
        OP_ENROLL_CB      = 3'd2,
        OP_WRITE_PLAIN    = 3'd3,
        OP_WRITE_CB       = 3'd4,
        OP_READ_PLAIN     = 3'd5,
        OP_READ_CB        = 3'd6
    } op_t;

endpackage

`default_nettype wire

[hw/rtl/stbt_req_if.sv]
`default_nettype none

interface stbt_req_if
    import stbt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   op;
    logic [SLOT_BITS-1:0] slot;
    logic [LOAD_BITS-1:0] load_delay;
    logic [LOAD_BITS-1:0] load_period;

    modport source (output valid, op, slot, load_delay, load_period, input ready);
    modport sink   (input valid, op, slot, load_delay, load_period, output ready);
endinterface

`default_nettype wire

[hw/rtl/stbt_rsp_if.sv]
`default_nettype none

interface stbt_rsp_if
    import stbt_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [MASK_BITS-1:0]  expired_mask;
    logic [VALUE_BITS-1:0] read_value;

    modport source (output valid, expired_mask, read_value, input ready);
    modport sink   (input valid, expired_mask, read_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/software_timer_bank_tick_unit.sv]
// Millisecond countdown timer bank with plain and callback slots.
// Channel req carries one operation per transaction: tick, enroll a slot,
// write a slot's count (and period for callback slots), or read a count.
// Channel rsp returns one transaction per request: the expiry mask of the
// callback slots that reached zero on a tick, and the count on a read.
// Each response passes through the input register, then the response
// register, before it is valid on rsp. Throughput: one request per cycle
// while the receiver does not stall; on a tick every slot updates in
// parallel through its own decrementer in the cycle the request leaves
// the input register.
// A request is accepted while the input register is empty or moving on, so
// a response waiting in the output register does not block a new request.
// When the receiver stalls, the response is held and the input register
// fills; req.ready then drops until rsp.ready returns.
// Reset clears all counts, periods and enroll bits and empties both
// registers; the block accepts requests in the first cycle after reset.
`default_nettype none

module software_timer_bank_tick_unit
    import stbt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    stbt_req_if.sink    req,
    stbt_rsp_if.source  rsp
);

    // input register
    logic                 s1_valid_reg;
    op_t                  s1_op_reg;
    logic [SLOT_BITS-1:0] s1_slot_reg;
    count_t               s1_delay_reg;
    count_t               s1_period_reg;
    logic                 s1_adv;

    // response register
    logic                  out_valid_reg;
    logic [MASK_BITS-1:0]  out_mask_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [MASK_BITS-1:0]  out_mask_next;
    logic [VALUE_BITS-1:0] out_value_next;

    // slot state
    count_t                    plain_rem_reg  [PLAIN_SLOTS];
    count_t                    plain_rem_next [PLAIN_SLOTS];
    logic [PLAIN_SLOTS-1:0]    plain_enr_reg;
    logic [PLAIN_SLOTS-1:0]    plain_enr_next;
    count_t                    cb_rem_reg     [CALLBACK_SLOTS];
    count_t                    cb_rem_next    [CALLBACK_SLOTS];
    count_t                    cb_reload_reg  [CALLBACK_SLOTS];
    count_t                    cb_reload_next [CALLBACK_SLOTS];
    logic [CALLBACK_SLOTS-1:0] cb_enr_reg;
    logic [CALLBACK_SLOTS-1:0] cb_enr_next;
    logic [CALLBACK_SLOTS-1:0] cb_fired;
    count_t                    read_sel;

    // handshake
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;

    assign rsp.valid        = out_valid_reg;
    assign rsp.expired_mask = out_mask_reg;
    assign rsp.read_value   = out_value_reg;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg     <= op_t'(req.op);
            s1_slot_reg   <= req.slot;
            s1_delay_reg  <= COUNT_BITS'(req.load_delay);
            s1_period_reg <= COUNT_BITS'(req.load_period);
        end
    end

    // slot updates and response for the item in the input register
    always_comb
    begin
        plain_rem_next = plain_rem_reg;
        plain_enr_next = plain_enr_reg;
        cb_rem_next    = cb_rem_reg;
        cb_reload_next = cb_reload_reg;
        cb_enr_next    = cb_enr_reg;
        cb_fired       = '0;
        read_sel       = '0;
        out_mask_next  = '0;
        out_value_next = '0;

        unique case (s1_op_reg)
            OP_TICK:
            begin
                for (int i = 0; i < PLAIN_SLOTS; i++)
                begin
                    if (plain_enr_reg[i] && (plain_rem_reg[i] != '0))
                    begin
                        plain_rem_next[i] = plain_rem_reg[i] - 1'b1;
                    end
                end
                for (int i = 0; i < CALLBACK_SLOTS; i++)
                begin
                    if (cb_enr_reg[i] && (cb_rem_reg[i] != '0))
                    begin
                        // reaching zero fires and reloads the period
                        if (cb_rem_reg[i] == COUNT_BITS'(1))
                        begin
                            cb_fired[i]    = 1'b1;
                            cb_rem_next[i] = cb_reload_reg[i];
                        end
                        else
                        begin
                            cb_rem_next[i] = cb_rem_reg[i] - 1'b1;
                        end
                    end
                end
                out_mask_next = MASK_BITS'(cb_fired);
            end
            OP_ENROLL_PLAIN:
            begin
                for (int i = 0; i < PLAIN_SLOTS; i++)
                begin
                    if (int'(s1_slot_reg) == i)
                    begin
                        plain_enr_next[i] = 1'b1;
                    end
                end
            end
            OP_ENROLL_CB:
            begin
                for (int i = 0; i < CALLBACK_SLOTS; i++)
                begin
                    if (int'(s1_slot_reg) == i)
                    begin
                        cb_enr_next[i] = 1'b1;
                    end
                end
            end
            OP_WRITE_PLAIN:
            begin
                for (int i = 0; i < PLAIN_SLOTS; i++)
                begin
                    if (int'(s1_slot_reg) == i)
                    begin
                        plain_rem_next[i] = s1_delay_reg;
                    end
                end
            end
            OP_WRITE_CB:
            begin
                for (int i = 0; i < CALLBACK_SLOTS; i++)
                begin
                    if (int'(s1_slot_reg) == i)
                    begin
                        cb_rem_next[i]    = s1_delay_reg;
                        cb_reload_next[i] = s1_period_reg;
                    end
                end
            end
            OP_READ_PLAIN:
            begin
                for (int i = 0; i < PLAIN_SLOTS; i++)
                begin
                    if (int'(s1_slot_reg) == i)
                    begin
                        read_sel = plain_rem_reg[i];
                    end
                end
                out_value_next = VALUE_BITS'(read_sel);
            end
            OP_READ_CB:
            begin
                for (int i = 0; i < CALLBACK_SLOTS; i++)
                begin
                    if (int'(s1_slot_reg) == i)
                    begin
                        read_sel = cb_rem_reg[i];
                    end
                end
                out_value_next = VALUE_BITS'(read_sel);
            end
            default:
            begin
                // unused code: no change, zero response
            end
        endcase
    end

    // slot state registers, updated when the item moves to the response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLAIN_SLOTS; i++)
            begin
                plain_rem_reg[i] <= '0;
            end
            for (int i = 0; i < CALLBACK_SLOTS; i++)
            begin
                cb_rem_reg[i]    <= '0;
                cb_reload_reg[i] <= '0;
            end
            plain_enr_reg <= '0;
            cb_enr_reg    <= '0;
        end
        else if (s1_adv)
        begin
            plain_rem_reg <= plain_rem_next;
            cb_rem_reg    <= cb_rem_next;
            cb_reload_reg <= cb_reload_next;
            plain_enr_reg <= plain_enr_next;
            cb_enr_reg    <= cb_enr_next;
        end
    end

    // response register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // response register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_mask_reg  <= out_mask_next;
            out_value_reg <= out_value_next;
        end
    end

`ifndef SYNTHESIS
    // only a tick can report expiries
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_op_reg != OP_TICK)) |=> (out_mask_reg == '0))
        else $error("expiry mask set for a non-tick transaction");

    // only reads return a count
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_op_reg != OP_READ_PLAIN) && (s1_op_reg != OP_READ_CB))
        |=> (out_value_reg == '0))
        else $error("read value set for a non-read transaction");

    // requests are refused only when both registers are full and rsp.ready is low
    assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg && !rsp.ready))
        else $error("request refused with room in the pipeline");

    // enroll bits never clear
    assert property (@(posedge clk) disable iff (!rst_n)
        ((plain_enr_reg & ~plain_enr_next) == '0) && ((cb_enr_reg & ~cb_enr_next) == '0))
        else $error("enroll bit cleared");
`endif

endmodule

`default_nettype wire
